// ----- rtl/ohlc_bar_tick_generator_defines.svh -----
// ----------------------------------------------------------------------------
// ohlc bar tick generator assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef OHLC_BAR_TICK_GENERATOR_DEFINES_SVH
`define OHLC_BAR_TICK_GENERATOR_DEFINES_SVH

// property checked outside reset
`define OBTG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("obtg check failed");

// property that also spans the reset cycles
`define OBTG_ASSERT_RESET(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("obtg reset check failed");

`endif

// ----- rtl/obtg_pkg.sv -----
// ----------------------------------------------------------------------------
// obtg_pkg
// widths, register indexes and the job record passed from front to back
// ----------------------------------------------------------------------------
package obtg_pkg;

   localparam int MAX_SUPPORT = 20;

   localparam int TIME_W     = 48;
   localparam int PRICE_W    = 40;
   localparam int SPREAD_W   = 17;
   localparam int FRAC_W     = 8;
   localparam int BID_W      = 48;
   localparam int ASK_W      = 49;
   localparam int DQ_W       = 49;
   localparam int STEP_W     = 5;
   localparam int COUNT_W    = 6;
   localparam int PS_W       = 24;
   localparam int DS_W       = 16;
   localparam int SC_W       = 5;
   localparam int ADD_W      = PS_W + DS_W;

   // divider retires this many quotient bits per cycle
   localparam int DIV_DIGIT  = 4;
   localparam int DIV_STEPS  = BID_W / DIV_DIGIT;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_SIZE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_SPREAD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPORT_COUNT  = 2'd2;

   // depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] LEG_FIRST = 2'd0;
   localparam logic [1:0] LEG_MID   = 2'd1;
   localparam logic [1:0] LEG_LAST  = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] bar_time;
      logic [BID_W-1:0]  base_bid0;
      logic [BID_W-1:0]  base_bid1;
      logic [BID_W-1:0]  base_bid2;
      logic [ASK_W-1:0]  base_ask0;
      logic [ASK_W-1:0]  base_ask1;
      logic [ASK_W-1:0]  base_ask2;
      logic [DQ_W-1:0]   dq0;
      logic [DQ_W-1:0]   dq1;
      logic [DQ_W-1:0]   dq2;
      logic [STEP_W-1:0] dr0;
      logic [STEP_W-1:0] dr1;
      logic [STEP_W-1:0] dr2;
   } job_type;

   // steps per leg: support count saturated, plus one
   function automatic logic [STEP_W-1:0] steps_for(input logic [SC_W-1:0] sc);
      logic [STEP_W-1:0] n;
      n = (sc > SC_W'(MAX_SUPPORT)) ? STEP_W'(MAX_SUPPORT) : STEP_W'(sc);
      return n + STEP_W'(1);
   endfunction

endpackage

// ----- rtl/ohlc_bar_tick_generator.sv -----
// path: an accepted bar goes through the front divider and the job queue to the back end
// throughput: one tick per cycle while results are taken; a bar gives 3*(n+1)+1 ticks, and
// the front divider works on one bar at a time while the next waits in its input register
// reset: synchronous, clears the queues and handshakes and loads point_size 1,
// default_spread 0, support_count 0; no clearing pass
// ----------------------------------------------------------------------------
// ohlc_bar_tick_generator
// turns each price bar into an interpolated open-low-high-close or open-high-low-close tick path
// ----------------------------------------------------------------------------
module ohlc_bar_tick_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [obtg_pkg::TIME_W-1:0]          req_bar_time,
   input  logic [obtg_pkg::PRICE_W-1:0]         req_open_price,
   input  logic [obtg_pkg::PRICE_W-1:0]         req_high_price,
   input  logic [obtg_pkg::PRICE_W-1:0]         req_low_price,
   input  logic [obtg_pkg::PRICE_W-1:0]         req_close_price,
   input  logic signed [obtg_pkg::SPREAD_W-1:0] req_bar_spread,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [obtg_pkg::TIME_W-1:0]          rsp_tick_time,
   output logic [obtg_pkg::BID_W-1:0]           rsp_bid_price,
   output logic [obtg_pkg::ASK_W-1:0]           rsp_ask_price,
   output logic                                 rsp_last_in_bar,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [obtg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [obtg_pkg::CSR_DATA_W-1:0]      csr_data
);
   import obtg_pkg::*;

   logic [PS_W-1:0]   point_ff, point_in;
   logic [DS_W-1:0]   dspread_ff, dspread_in;
   logic [SC_W-1:0]   scount_ff, scount_in;
   logic [STEP_W-1:0] steps;

   logic              q_push, q_full, q_pop, q_empty;
   job_type           q_wdata, q_rdata;

   assign csr_ready = 1'b1;
   assign steps     = steps_for(scount_ff);

   always_comb begin
      point_in   = point_ff;
      dspread_in = dspread_ff;
      scount_in  = scount_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POINT_SIZE:     point_in   = csr_data[PS_W-1:0];
            CSR_DEFAULT_SPREAD: dspread_in = csr_data[DS_W-1:0];
            CSR_SUPPORT_COUNT:  scount_in  = csr_data[SC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff   <= PS_W'(1);
         dspread_ff <= '0;
         scount_ff  <= '0;
      end else begin
         point_ff   <= point_in;
         dspread_ff <= dspread_in;
         scount_ff  <= scount_in;
      end
   end

   obtg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_push        (req_push),
      .in_full        (req_full),
      .in_bar_time    (req_bar_time),
      .in_open_price  (req_open_price),
      .in_high_price  (req_high_price),
      .in_low_price   (req_low_price),
      .in_close_price (req_close_price),
      .in_bar_spread  (req_bar_spread),
      .point_size     (point_ff),
      .default_spread (dspread_ff),
      .steps          (steps),
      .job_push       (q_push),
      .job            (q_wdata),
      .job_full       (q_full)
   );

   obtg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   obtg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job         (q_rdata),
      .job_empty   (q_empty),
      .job_pop     (q_pop),
      .steps       (steps),
      .pop         (rsp_pop),
      .empty       (rsp_empty),
      .tick_time   (rsp_tick_time),
      .bid_price   (rsp_bid_price),
      .ask_price   (rsp_ask_price),
      .last_in_bar (rsp_last_in_bar)
   );

endmodule

// ----- rtl/obtg_front.sv -----
// ----------------------------------------------------------------------------
// obtg_front
// takes bars, orders the price path and divides each leg's span into
// per-step quotient and remainder increments for the back end
// ----------------------------------------------------------------------------
module obtg_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_push,
   output logic                               in_full,
   input  logic [obtg_pkg::TIME_W-1:0]        in_bar_time,
   input  logic [obtg_pkg::PRICE_W-1:0]       in_open_price,
   input  logic [obtg_pkg::PRICE_W-1:0]       in_high_price,
   input  logic [obtg_pkg::PRICE_W-1:0]       in_low_price,
   input  logic [obtg_pkg::PRICE_W-1:0]       in_close_price,
   input  logic signed [obtg_pkg::SPREAD_W-1:0] in_bar_spread,
   input  logic [obtg_pkg::PS_W-1:0]          point_size,
   input  logic [obtg_pkg::DS_W-1:0]          default_spread,
   input  logic [obtg_pkg::STEP_W-1:0]        steps,
   output logic                               job_push,
   output obtg_pkg::job_type                  job,
   input  logic                               job_full
);
   import obtg_pkg::*;

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_LOAD = 3'd1;
   localparam logic [2:0] F_DIV  = 3'd2;
   localparam logic [2:0] F_FIN  = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   logic                  in_valid_ff, in_valid_in;
   logic [TIME_W-1:0]     in_time_ff, in_time_in;
   logic [PRICE_W-1:0]    in_open_ff, in_open_in;
   logic [PRICE_W-1:0]    in_high_ff, in_high_in;
   logic [PRICE_W-1:0]    in_low_ff, in_low_in;
   logic [PRICE_W-1:0]    in_close_ff, in_close_in;
   logic [SPREAD_W-1:0]   in_spread_ff, in_spread_in;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            leg_ff, leg_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PRICE_W-1:0]    p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic [BID_W-1:0]      add_ff, add_in;
   logic                  neg_ff, neg_in;
   logic [BID_W-1:0]      dvd_ff, dvd_in;
   logic [BID_W-1:0]      quo_ff, quo_in;
   logic [STEP_W-1:0]     rem_ff, rem_in;
   job_type               job_ff, job_in;

   logic                  accept, grab;
   logic [DS_W-1:0]       spread_sel;
   logic [ADD_W-1:0]      prod;
   logic [PRICE_W-1:0]    leg_a, leg_b;
   logic [PRICE_W:0]      diff_ba, diff_ab;
   logic [BID_W-1:0]      dvd_v, quo_v;
   logic [STEP_W-1:0]     rem_v;
   logic [STEP_W:0]       trial;
   logic [DQ_W-1:0]       dq_v;
   logic [STEP_W-1:0]     dr_v;
   logic                  rnz;
   logic [BID_W-1:0]      base_bid_v;
   logic [ASK_W-1:0]      base_ask_v;

   assign in_full  = in_valid_ff;
   assign accept   = in_push && !in_valid_ff;
   assign job_push = (state_ff == F_PUSH) && !job_full;
   assign job      = job_ff;
   assign grab     = in_valid_ff && ((state_ff == F_IDLE) || job_push);

   assign spread_sel = in_spread_ff[SPREAD_W-1] ? default_spread : in_spread_ff[DS_W-1:0];
   assign prod = {{PS_W{1'b0}}, spread_sel} * {{DS_W{1'b0}}, point_size};

   always_comb begin
      case (leg_ff)
         LEG_FIRST: begin
            leg_a = p0_ff;
            leg_b = p1_ff;
         end
         LEG_MID: begin
            leg_a = p1_ff;
            leg_b = p2_ff;
         end
         default: begin
            leg_a = p2_ff;
            leg_b = p3_ff;
         end
      endcase
   end

   assign diff_ba = {1'b0, leg_b} - {1'b0, leg_a};
   assign diff_ab = {1'b0, leg_a} - {1'b0, leg_b};

   // four restoring division steps per cycle on a narrow remainder
   always_comb begin
      dvd_v = dvd_ff;
      quo_v = quo_ff;
      rem_v = rem_ff;
      trial = '0;
      for (int i = 0; i < DIV_DIGIT; i++) begin
         trial = {rem_v, dvd_v[BID_W-1]};
         dvd_v = {dvd_v[BID_W-2:0], 1'b0};
         if (trial >= {1'b0, steps}) begin
            rem_v = STEP_W'(trial - {1'b0, steps});
            quo_v = {quo_v[BID_W-2:0], 1'b1};
         end else begin
            rem_v = trial[STEP_W-1:0];
            quo_v = {quo_v[BID_W-2:0], 1'b0};
         end
      end
   end

   // falling leg: floor of a negative quotient, remainder kept non-negative
   assign rnz  = rem_ff != '0;
   assign dq_v = neg_ff ? (~{1'b0, quo_ff} + {{(DQ_W-1){1'b0}}, !rnz}) : {1'b0, quo_ff};
   assign dr_v = (neg_ff && rnz) ? (steps - rem_ff) : rem_ff;
   assign base_bid_v = {leg_a, {FRAC_W{1'b0}}};
   assign base_ask_v = {1'b0, base_bid_v} + {1'b0, add_ff};

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_time_in   = in_time_ff;
      in_open_in   = in_open_ff;
      in_high_in   = in_high_ff;
      in_low_in    = in_low_ff;
      in_close_in  = in_close_ff;
      in_spread_in = in_spread_ff;
      state_in     = state_ff;
      leg_in       = leg_ff;
      cnt_in       = cnt_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      p3_in        = p3_ff;
      add_in       = add_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      job_in       = job_ff;

      if (accept) begin
         in_valid_in  = 1'b1;
         in_time_in   = in_bar_time;
         in_open_in   = in_open_price;
         in_high_in   = in_high_price;
         in_low_in    = in_low_price;
         in_close_in  = in_close_price;
         in_spread_in = in_bar_spread;
      end

      case (state_ff)
         F_IDLE: begin
         end
         F_LOAD: begin
            neg_in = diff_ba[PRICE_W];
            dvd_in = {(diff_ba[PRICE_W] ? diff_ab[PRICE_W-1:0] : diff_ba[PRICE_W-1:0]),
                      {FRAC_W{1'b0}}};
            quo_in = '0;
            rem_in = '0;
            cnt_in = '0;
            state_in = F_DIV;
         end
         F_DIV: begin
            dvd_in = dvd_v;
            quo_in = quo_v;
            rem_in = rem_v;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = F_FIN;
            end
         end
         F_FIN: begin
            case (leg_ff)
               LEG_FIRST: begin
                  job_in.base_bid0 = base_bid_v;
                  job_in.base_ask0 = base_ask_v;
                  job_in.dq0 = dq_v;
                  job_in.dr0 = dr_v;
               end
               LEG_MID: begin
                  job_in.base_bid1 = base_bid_v;
                  job_in.base_ask1 = base_ask_v;
                  job_in.dq1 = dq_v;
                  job_in.dr1 = dr_v;
               end
               default: begin
                  job_in.base_bid2 = base_bid_v;
                  job_in.base_ask2 = base_ask_v;
                  job_in.dq2 = dq_v;
                  job_in.dr2 = dr_v;
               end
            endcase
            if (leg_ff == LEG_LAST) begin
               state_in = F_PUSH;
            end else begin
               leg_in   = leg_ff + 2'd1;
               state_in = F_LOAD;
            end
         end
         F_PUSH: begin
            if (job_push) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase

      if (grab) begin
         in_valid_in = 1'b0;
         p0_in = in_open_ff;
         if (in_close_ff >= in_open_ff) begin
            p1_in = in_low_ff;
            p2_in = in_high_ff;
         end else begin
            p1_in = in_high_ff;
            p2_in = in_low_ff;
         end
         p3_in = in_close_ff;
         add_in = {prod, {FRAC_W{1'b0}}};
         job_in.bar_time = in_time_ff;
         leg_in   = LEG_FIRST;
         state_in = F_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= F_IDLE;
         leg_ff      <= LEG_FIRST;
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         leg_ff      <= leg_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_time_ff   <= in_time_in;
      in_open_ff   <= in_open_in;
      in_high_ff   <= in_high_in;
      in_low_ff    <= in_low_in;
      in_close_ff  <= in_close_in;
      in_spread_ff <= in_spread_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      p3_ff        <= p3_in;
      add_ff       <= add_in;
      neg_ff       <= neg_in;
      dvd_ff       <= dvd_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      job_ff       <= job_in;
   end

endmodule

// ----- rtl/obtg_queue.sv -----
// ----------------------------------------------------------------------------
// obtg_queue
// short job queue between the front and the back end
// ----------------------------------------------------------------------------
module obtg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  obtg_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output obtg_pkg::job_type pop_data,
   output logic              empty
);
   import obtg_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   job_type                mem_in [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         mem_in[wr_ptr_ff] = push_data;
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

endmodule

// ----- rtl/obtg_back.sv -----
// ----------------------------------------------------------------------------
// obtg_back
// walks the three legs of a job, one tick per cycle while the result register is free or popped,
// into the result register
module obtg_back (
   input  logic                         clock,
   input  logic                         reset,
   input  obtg_pkg::job_type            job,
   input  logic                         job_empty,
   output logic                         job_pop,
   input  logic [obtg_pkg::STEP_W-1:0]  steps,
   input  logic                         pop,
   output logic                         empty,
   output logic [obtg_pkg::TIME_W-1:0]  tick_time,
   output logic [obtg_pkg::BID_W-1:0]   bid_price,
   output logic [obtg_pkg::ASK_W-1:0]   ask_price,
   output logic                         last_in_bar
);
   import obtg_pkg::*;

   logic                busy_ff, busy_in;
   logic [1:0]          leg_ff, leg_in;
   logic [STEP_W-1:0]   j_ff, j_in;
   logic [DQ_W-1:0]     q_ff, q_in;
   logic [STEP_W-1:0]   r_ff, r_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   job_type             job_ff, job_in;
   logic                out_valid_ff, out_valid_in;
   logic [TIME_W-1:0]   out_time_ff, out_time_in;
   logic [BID_W-1:0]    out_bid_ff, out_bid_in;
   logic [ASK_W-1:0]    out_ask_ff, out_ask_in;
   logic                out_last_ff, out_last_in;

   logic                advance, leg_end, last_tick, load, wrap;
   logic [STEP_W-1:0]   half;
   logic [1:0]          sel_leg;
   logic [BID_W-1:0]    cur_bid;
   logic [ASK_W-1:0]    cur_ask;
   logic [DQ_W-1:0]     dq_sel, base_q;
   logic [STEP_W-1:0]   dr_sel, base_r;
   logic [STEP_W:0]     rsum;

   assign half      = steps >> 1;
   assign advance   = busy_ff && (!out_valid_ff || pop);
   assign leg_end   = j_ff == steps;
   assign last_tick = leg_end && (leg_ff == LEG_LAST);
   assign load      = !job_empty && (!busy_ff || (advance && last_tick));
   assign job_pop   = load;

   assign empty       = !out_valid_ff;
   assign tick_time   = out_time_ff;
   assign bid_price   = out_bid_ff;
   assign ask_price   = out_ask_ff;
   assign last_in_bar = out_last_ff;

   always_comb begin
      case (leg_ff)
         LEG_FIRST: begin
            cur_bid = job_ff.base_bid0;
            cur_ask = job_ff.base_ask0;
         end
         LEG_MID: begin
            cur_bid = job_ff.base_bid1;
            cur_ask = job_ff.base_ask1;
         end
         default: begin
            cur_bid = job_ff.base_bid2;
            cur_ask = job_ff.base_ask2;
         end
      endcase
   end

   // at a leg end the walk restarts from the next leg's start point
   assign sel_leg = leg_end ? (leg_ff + 2'd1) : leg_ff;

   always_comb begin
      case (sel_leg)
         LEG_FIRST: begin
            dq_sel = job_ff.dq0;
            dr_sel = job_ff.dr0;
         end
         LEG_MID: begin
            dq_sel = job_ff.dq1;
            dr_sel = job_ff.dr1;
         end
         default: begin
            dq_sel = job_ff.dq2;
            dr_sel = job_ff.dr2;
         end
      endcase
   end

   assign base_q = leg_end ? '0 : q_ff;
   assign base_r = leg_end ? half : r_ff;
   assign rsum   = {1'b0, base_r} + {1'b0, dr_sel};
   assign wrap   = rsum >= {1'b0, steps};

   always_comb begin
      busy_in      = busy_ff;
      leg_in       = leg_ff;
      j_in         = j_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      count_in     = count_ff;
      job_in       = job_ff;
      out_valid_in = out_valid_ff;
      out_time_in  = out_time_ff;
      out_bid_in   = out_bid_ff;
      out_ask_in   = out_ask_ff;
      out_last_in  = out_last_ff;

      if (pop) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         out_valid_in = 1'b1;
         out_time_in  = job_ff.bar_time + {{(TIME_W-COUNT_W){1'b0}}, count_ff};
         out_bid_in   = cur_bid + q_ff[BID_W-1:0];
         out_ask_in   = cur_ask + q_ff[ASK_W-1:0];
         out_last_in  = last_tick;
         if (last_tick) begin
            busy_in = 1'b0;
         end else begin
            leg_in   = sel_leg;
            j_in     = leg_end ? STEP_W'(1) : (j_ff + STEP_W'(1));
            q_in     = base_q + dq_sel + {{(DQ_W-1){1'b0}}, wrap};
            r_in     = wrap ? STEP_W'(rsum - {1'b0, steps}) : rsum[STEP_W-1:0];
            count_in = count_ff + COUNT_W'(1);
         end
      end

      if (load) begin
         busy_in  = 1'b1;
         job_in   = job;
         leg_in   = LEG_FIRST;
         j_in     = '0;
         q_in     = '0;
         r_in     = half;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         leg_ff       <= LEG_FIRST;
         j_ff         <= '0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         leg_ff       <= leg_in;
         j_ff         <= j_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      r_ff        <= r_in;
      job_ff      <= job_in;
      out_time_ff <= out_time_in;
      out_bid_ff  <= out_bid_in;
      out_ask_ff  <= out_ask_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ----- rtl/obtg_checker.sv -----
// ----------------------------------------------------------------------------
// obtg_checker
// port-level checks on the tick generator, bound to the top level
// ----------------------------------------------------------------------------
`include "ohlc_bar_tick_generator_defines.svh"

module obtg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_full,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic [obtg_pkg::TIME_W-1:0]          rsp_tick_time,
   input logic [obtg_pkg::BID_W-1:0]           rsp_bid_price,
   input logic [obtg_pkg::ASK_W-1:0]           rsp_ask_price,
   input logic                                 rsp_last_in_bar
);
   import obtg_pkg::*;

   // nothing pending and the input side open right after reset
   `OBTG_ASSERT_RESET(a_reset_clears, clock, reset |=> (rsp_empty && !req_full))

   // a waiting result holds until taken
   `OBTG_ASSERT(a_rsp_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_tick_time) &&
      $stable(rsp_bid_price) && $stable(rsp_ask_price)))

   // ticks of one bar follow at consecutive times
   `OBTG_ASSERT(a_tick_step, clock, reset,
      (rsp_pop && !rsp_empty && !rsp_last_in_bar) |=>
      (rsp_empty || (rsp_tick_time == $past(rsp_tick_time) + TIME_W'(1))))

   // spread is never negative, so ask never falls below bid
   `OBTG_ASSERT(a_ask_above_bid, clock, reset, !rsp_empty |-> (rsp_ask_price >= {1'b0, rsp_bid_price}))

endmodule

bind ohlc_bar_tick_generator obtg_checker u_obtg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_tick_time   (rsp_tick_time),
   .rsp_bid_price   (rsp_bid_price),
   .rsp_ask_price   (rsp_ask_price),
   .rsp_last_in_bar (rsp_last_in_bar)
);

// ----- tb/sv/tb_ohlc_bar_tick_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ohlc_bar_tick_generator
// sends price bars through the request queue and checks every tick that
// comes back against a path predictor kept in step with the register writes;
// runs directed corner bars, then random phases under changing settings and
// either steady or with gaps on the request side, stalls on the tick side, or both
// ----------------------------------------------------------------------------
module tb_ohlc_bar_tick_generator;
   import obtg_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int PRINT_LIMIT    = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      FLOW_STEADY,
      FLOW_SEND_GAPS,
      FLOW_RECV_STALLS,
      FLOW_BOTH
   } flow_type;

   typedef struct packed {
      logic [TIME_W-1:0]   bar_time;
      logic [PRICE_W-1:0]  open_price;
      logic [PRICE_W-1:0]  high_price;
      logic [PRICE_W-1:0]  low_price;
      logic [PRICE_W-1:0]  close_price;
      logic [SPREAD_W-1:0] bar_spread;
   } bar_type;

   typedef struct packed {
      logic [TIME_W-1:0] tick_time;
      logic [BID_W-1:0]  bid_price;
      logic [ASK_W-1:0]  ask_price;
      logic              last_in_bar;
   } tick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [TIME_W-1:0]          req_bar_time = '0;
   logic [PRICE_W-1:0]         req_open_price = '0;
   logic [PRICE_W-1:0]         req_high_price = '0;
   logic [PRICE_W-1:0]         req_low_price = '0;
   logic [PRICE_W-1:0]         req_close_price = '0;
   logic signed [SPREAD_W-1:0] req_bar_spread = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [TIME_W-1:0]          rsp_tick_time;
   logic [BID_W-1:0]           rsp_bid_price;
   logic [ASK_W-1:0]           rsp_ask_price;
   logic                       rsp_last_in_bar;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // register copies for prediction
   logic [PS_W-1:0] cfg_point_size     = PS_W'(1);
   logic [DS_W-1:0] cfg_default_spread = '0;
   logic [SC_W-1:0] cfg_support_count  = '0;

   flow_type flow_mode = FLOW_STEADY;
   bar_type  pending_bars[$];
   tick_type expected_ticks[$];
   int       fail_count = 0;
   int       quiet_cycles = 0;

   ohlc_bar_tick_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_bar_time    (req_bar_time),
      .req_open_price  (req_open_price),
      .req_high_price  (req_high_price),
      .req_low_price   (req_low_price),
      .req_close_price (req_close_price),
      .req_bar_spread  (req_bar_spread),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_tick_time   (rsp_tick_time),
      .rsp_bid_price   (rsp_bid_price),
      .rsp_ask_price   (rsp_ask_price),
      .rsp_last_in_bar (rsp_last_in_bar),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < PRINT_LIMIT)
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // walks open -> low/high -> high/low -> close and queues every tick
   function automatic void expand_bar_ticks(input bar_type b);
      logic [PRICE_W-1:0] corner[4];
      logic [63:0] steps;
      logic [63:0] spread;
      logic [63:0] markup;
      logic [63:0] num;
      logic [63:0] j;
      logic [BID_W-1:0] bid;
      tick_type tk;
      int leg;
      int unsigned idx;
      int unsigned total;
      steps = (cfg_support_count > SC_W'(MAX_SUPPORT)) ? 64'(MAX_SUPPORT)
                                                       : 64'(cfg_support_count);
      steps = steps + 1;
      total = 3 * int'(steps) + 1;
      if (b.bar_spread[SPREAD_W-1])
         spread = 64'(cfg_default_spread);
      else
         spread = 64'(b.bar_spread[SPREAD_W-2:0]);
      markup = spread * 64'(cfg_point_size) * 64'd256;
      corner[0] = b.open_price;
      if (b.close_price >= b.open_price) begin
         corner[1] = b.low_price;
         corner[2] = b.high_price;
      end else begin
         corner[1] = b.high_price;
         corner[2] = b.low_price;
      end
      corner[3] = b.close_price;
      idx = 0;
      for (leg = 0; leg < 3; leg++) begin
         for (j = (leg == 0) ? 64'd0 : 64'd1; j <= steps; j++) begin
            num = (64'(corner[leg]) * (steps - j) + 64'(corner[leg+1]) * j) * 64'd256;
            bid = BID_W'((num + steps / 2) / steps);
            tk.tick_time   = TIME_W'(64'(b.bar_time) + 64'(idx));
            tk.bid_price   = bid;
            tk.ask_price   = ASK_W'(64'(bid) + markup);
            tk.last_in_bar = (idx == total - 1);
            expected_ticks = {expected_ticks, tk};
            idx++;
         end
      end
   endfunction

   function automatic bit sender_waits();
      return (flow_mode == FLOW_SEND_GAPS && $urandom_range(0, 99) < 87) ||
             (flow_mode == FLOW_BOTH && $urandom_range(0, 99) < 12);
   endfunction

   function automatic bit receiver_stalls();
      return (flow_mode == FLOW_RECV_STALLS && $urandom_range(0, 99) < 87) ||
             (flow_mode == FLOW_BOTH && $urandom_range(0, 99) < 12);
   endfunction

   function automatic bar_type make_bar(input logic [TIME_W-1:0] t,
                                        input logic [PRICE_W-1:0] o,
                                        input logic [PRICE_W-1:0] h,
                                        input logic [PRICE_W-1:0] l,
                                        input logic [PRICE_W-1:0] c,
                                        input logic [SPREAD_W-1:0] s);
      bar_type b;
      b.bar_time    = t;
      b.open_price  = o;
      b.high_price  = h;
      b.low_price   = l;
      b.close_price = c;
      b.bar_spread  = s;
      return b;
   endfunction

   function automatic void queue_bar(input bar_type b);
      pending_bars = {pending_bars, b};
   endfunction

   // mostly sane bars around a random level, the rest fully random
   function automatic bar_type random_bar();
      bar_type b;
      logic [PRICE_W-1:0] span;
      b.bar_time = TIME_W'({$urandom, $urandom});
      if ($urandom_range(0, 9) == 0)
         b.bar_time = '1 - TIME_W'($urandom_range(0, 70));
      if ($urandom_range(0, 9) < 7) begin
         b.low_price   = PRICE_W'({$urandom, $urandom});
         span          = PRICE_W'({$urandom, $urandom}) >> $urandom_range(4, 39);
         b.high_price  = b.low_price + span;
         b.open_price  = b.low_price + PRICE_W'({$urandom, $urandom}) % (span + 1);
         b.close_price = b.low_price + PRICE_W'({$urandom, $urandom}) % (span + 1);
      end else begin
         b.open_price  = PRICE_W'({$urandom, $urandom});
         b.high_price  = PRICE_W'({$urandom, $urandom});
         b.low_price   = PRICE_W'({$urandom, $urandom});
         b.close_price = PRICE_W'({$urandom, $urandom});
      end
      case ($urandom_range(0, 3))
         0: b.bar_spread = '1;
         1: b.bar_spread = SPREAD_W'($urandom);
         default: b.bar_spread = SPREAD_W'($urandom_range(0, 200));
      endcase
      return b;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_POINT_SIZE:     cfg_point_size     = value[PS_W-1:0];
         CSR_DEFAULT_SPREAD: cfg_default_spread = value[DS_W-1:0];
         CSR_SUPPORT_COUNT:  cfg_support_count  = value[SC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_bars.size() != 0 || req_push || expected_ticks.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : bar_driver
      bar_type next_bar;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full)
            expand_bar_ticks(pending_bars.pop_front());
         // a blocked request stays on the ports until taken
         if (!req_push || !req_full) begin
            if (pending_bars.size() != 0 && !sender_waits()) begin
               next_bar = pending_bars[0];
               req_push        <= 1'b1;
               req_bar_time    <= next_bar.bar_time;
               req_open_price  <= next_bar.open_price;
               req_high_price  <= next_bar.high_price;
               req_low_price   <= next_bar.low_price;
               req_close_price <= next_bar.close_price;
               req_bar_spread  <= next_bar.bar_spread;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : tick_monitor
      tick_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_ticks.size() == 0) begin
               report_mismatch("tick with no bar outstanding", 64'(rsp_tick_time), 64'd0);
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_tick_time !== want.tick_time)
                  report_mismatch("tick_time", 64'(rsp_tick_time), 64'(want.tick_time));
               if (rsp_bid_price !== want.bid_price)
                  report_mismatch("bid_price", 64'(rsp_bid_price), 64'(want.bid_price));
               if (rsp_ask_price !== want.ask_price)
                  report_mismatch("ask_price", 64'(rsp_ask_price), 64'(want.ask_price));
               if (rsp_last_in_bar !== want.last_in_bar)
                  report_mismatch("last_in_bar", 64'(rsp_last_in_bar),
                                  64'(want.last_in_bar));
            end
         end
         rsp_pop <= !receiver_stalls();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] ps_word;
      logic [CSR_DATA_W-1:0] ds_word;
      logic [CSR_DATA_W-1:0] sc_word;
      int p;
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: four ticks per bar
      @(negedge clock);
      queue_bar(make_bar('0, '0, '0, '0, '0, '0));
      queue_bar(make_bar('1, '1, '1, '1, '1, 17'h0FFFF));
      queue_bar(make_bar(48'd1000, 40'd100, 40'd200, 40'd50, 40'd150, 17'd5));
      queue_bar(make_bar(48'd2000, 40'd150, 40'd200, 40'd50, 40'd100, '1));
      // flat bar takes the rising path
      queue_bar(make_bar(48'd3000, 40'd1000, 40'd1200, 40'd900, 40'd1000,
                         17'd7));
      // high below low is used as given
      queue_bar(make_bar(48'd4000, 40'd500, 40'd10, 40'd2000, 40'd400,
                         17'd3));
      queue_bar(make_bar(48'd5000, 40'd7, 40'd9, 40'd1, 40'd8, 17'h10000));
      queue_bar(make_bar(48'hFFFF_FFFF_FFFE, 40'hAA_AAAA_AAAA,
                         40'hFF_FFFF_FFFF, 40'h55_5555_5555,
                         40'h55_5555_5555, 17'h0AAAA));
      queue_bar(make_bar(48'h5555_5555_5555, 40'h55_5555_5555,
                         40'hAA_AAAA_AAAA, '0, 40'hAA_AAAA_AAAA,
                         17'h05555));
      wait_drained();

      // largest settings; support count above the limit saturates
      write_reg(CSR_POINT_SIZE, '1);
      write_reg(CSR_DEFAULT_SPREAD, '1);
      write_reg(CSR_SUPPORT_COUNT, 24'd31);
      write_reg(CSR_UNUSED, 24'hABCDEF);
      @(negedge clock);
      queue_bar(make_bar(48'hFFFF_FFFF_FFC0, '1, '1, '0, '1, 17'h0FFFF));
      queue_bar(make_bar(48'd77, '1, '1, '0, '0, '1));
      queue_bar(make_bar(48'd99, '0, '1, '0, '1, '0));
      wait_drained();

      // zero point size: ask equals bid
      write_reg(CSR_POINT_SIZE, '0);
      write_reg(CSR_DEFAULT_SPREAD, 24'h0004D2);
      write_reg(CSR_SUPPORT_COUNT, 24'd20);
      @(negedge clock);
      queue_bar(make_bar(48'd12345, 40'd1000003, 40'd1000777, 40'd999001,
                         40'd999500, 17'd100));
      queue_bar(make_bar(48'd54321, 40'd17, 40'd29, 40'd3, 40'd23, '1));
      wait_drained();

      // short legs with uneven division
      write_reg(CSR_POINT_SIZE, 24'd1);
      write_reg(CSR_DEFAULT_SPREAD, 24'd0);
      write_reg(CSR_SUPPORT_COUNT, 24'd2);
      @(negedge clock);
      queue_bar(make_bar(48'd10, 40'd1, 40'd2, 40'd0, 40'd2, '1));
      queue_bar(make_bar(48'd20, 40'd5, 40'd11, 40'd1, 40'd2, 17'd1));
      wait_drained();

      for (p = 0; p < 8; p++) begin
         case ($urandom_range(0, 3))
            0: ps_word = '0;
            1: ps_word = 24'd1;
            2: ps_word = '1;
            default: ps_word = CSR_DATA_W'($urandom);
         endcase
         ds_word = CSR_DATA_W'($urandom);
         case ($urandom_range(0, 2))
            0: ds_word[DS_W-1:0] = '0;
            1: ds_word[DS_W-1:0] = '1;
            default: ;
         endcase
         sc_word = CSR_DATA_W'($urandom);
         sc_word[SC_W-1:0] = (p % 4 == 3) ? SC_W'($urandom_range(20, 31))
                                          : SC_W'($urandom_range(0, 4));
         write_reg(CSR_POINT_SIZE, ps_word);
         write_reg(CSR_DEFAULT_SPREAD, ds_word);
         write_reg(CSR_SUPPORT_COUNT, sc_word);
         @(negedge clock);
         flow_mode = flow_type'(p % 4);
         for (k = 0; k < 14; k++)
            queue_bar(random_bar());
         wait_drained();
      end

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
